// ===== hdl/uri_percent_decoder_assert.svh =====
// Assertion macros for the URI percent decoder checker.
// Expects clk and rst in the scope where the macros are used.
`ifndef URI_PERCENT_DECODER_ASSERT_SVH
`define URI_PERCENT_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define UPD_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("uri_percent_decoder: check failed");

// Next-cycle implication, checked outside reset.
`define UPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("uri_percent_decoder: check failed");

`endif

// ===== hdl/upd_pkg.sv =====
// Shared types and character constants for the URI percent decoder.
// No dependencies.
package upd_pkg;

  localparam int MAX_RESULTS = 3;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [7:0] PCT_CHAR = 8'h25;
  localparam logic [7:0] DIG_0    = 8'h30;
  localparam logic [7:0] DIG_9    = 8'h39;
  localparam logic [7:0] HEX_A    = 8'h41;
  localparam logic [7:0] HEX_F    = 8'h46;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } res_t;

endpackage

// ===== hdl/uri_percent_decoder.sv =====
// URI percent decoder: escape scan logic and a three-slot result buffer.
// Depends on upd_pkg.
//
// Decodes "%XY" (X, Y upper-case hex digits) into one byte; a broken or
// unfinished escape is passed on unchanged and the breaking byte is scanned
// again as a fresh byte; s_tlast flushes held bytes and ends the string.
// An item that yields zero or one result is taken every cycle while m_tready is
// high, and its result shows on m_tvalid in the cycle after. An item that yields
// two or three results fills the three-slot output buffer, which drains one
// result per cycle while m_tready is high; s_tready stays low until the last leaves.
module uri_percent_decoder
  import upd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // in_last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast    // out_last
);

  phase_t           phase, phase_next;
  logic [7:0]       held, held_next;
  logic [CNT_W-1:0] cnt;
  res_t             slot [MAX_RESULTS];

  res_t             res [MAX_RESULTS];
  logic [CNT_W-1:0] res_n;
  logic             do_fresh;
  logic             fresh_emit;
  res_t             fresh_res;
  phase_t           fresh_phase;
  logic             is_hex;
  logic             pop, load;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    if (c <= DIG_9) begin
      return 4'(c - DIG_0);
    end
    return 4'(c - HEX_A + 8'd10);
  endfunction

  assign is_hex = ((s_tdata >= DIG_0) && (s_tdata <= DIG_9)) ||
                  ((s_tdata >= HEX_A) && (s_tdata <= HEX_F));

  // fresh scan of the current byte
  assign fresh_emit     = (s_tdata != PCT_CHAR) || s_tlast;
  assign fresh_res.data = s_tdata;
  assign fresh_res.last = s_tlast;
  assign fresh_phase    = ((s_tdata == PCT_CHAR) && !s_tlast) ? PH_PCT : PH_IDLE;

  always_comb begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      res[i] = '0;
    end
    res_n      = '0;
    phase_next = phase;
    held_next  = held;
    do_fresh   = 1'b0;
    case (phase)
      PH_PCT: begin
        if (is_hex) begin
          held_next = s_tdata;
          if (s_tlast) begin
            res[0]     = '{data: PCT_CHAR, last: 1'b0};
            res[1]     = '{data: s_tdata, last: 1'b1};
            res_n      = CNT_W'(2);
            phase_next = PH_IDLE;
          end else begin
            phase_next = PH_DIGIT;
          end
        end else begin
          res[0]   = '{data: PCT_CHAR, last: 1'b0};
          res_n    = CNT_W'(1);
          do_fresh = 1'b1;
        end
      end
      PH_DIGIT: begin
        if (is_hex) begin
          res[0]     = '{data: {hex_value(held), hex_value(s_tdata)}, last: s_tlast};
          res_n      = CNT_W'(1);
          phase_next = PH_IDLE;
        end else begin
          res[0]   = '{data: PCT_CHAR, last: 1'b0};
          res[1]   = '{data: held, last: 1'b0};
          res_n    = CNT_W'(2);
          do_fresh = 1'b1;
        end
      end
      default: begin
        do_fresh = 1'b1;
      end
    endcase
    if (do_fresh) begin
      phase_next = fresh_phase;
      if (fresh_emit) begin
        case (res_n)
          CNT_W'(0): res[0] = fresh_res;
          CNT_W'(1): res[1] = fresh_res;
          default:   res[2] = fresh_res;
        endcase
        res_n = CNT_W'(res_n + 1'b1);
      end
    end
  end

  assign m_tvalid = (cnt != '0);
  assign m_tdata  = slot[0].data;
  assign m_tlast  = slot[0].last;
  assign pop      = m_tvalid && m_tready;
  // take a request when the buffer is empty or its last result leaves now
  assign s_tready = (cnt == '0) || ((cnt == CNT_W'(1)) && m_tready);
  assign load     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      held  <= '0;
      cnt   <= '0;
    end else begin
      if (load) begin
        phase <= phase_next;
        held  <= held_next;
        cnt   <= res_n;
      end else if (pop) begin
        cnt <= CNT_W'(cnt - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        slot[i] <= res[i];
      end
    end else if (pop) begin
      // advance the queue toward the output slot
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        slot[i] <= slot[i+1];
      end
    end
  end

endmodule

// ===== hdl/upd_checker.sv =====
// Port-level checks for the URI percent decoder, bound to the top level.
// Depends on uri_percent_decoder_assert.svh.
`include "uri_percent_decoder_assert.svh"

module upd_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [7:0] s_tdata,
  input logic       s_tlast,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  // a stalled result holds
  `UPD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

  // an empty output side never blocks a request
  `UPD_ASSERT_IMPLY(a_ready_when_empty, !m_tvalid, s_tready)

  // the final byte of a string always produces output
  `UPD_ASSERT_NEXT(a_last_flushes, s_tvalid && s_tready && s_tlast, m_tvalid)

  // nothing pending right after reset
  `UPD_ASSERT_IMPLY(a_empty_after_reset, $past(rst), !m_tvalid)

endmodule

bind uri_percent_decoder upd_checker u_upd_checker (.*);
